/* design/ctq_pkg.sv */
package ctq_pkg;

    localparam logic [1:0] MODE_BEGIN = 2'd0;
    localparam logic [1:0] MODE_BYTE  = 2'd1;
    localparam logic [1:0] MODE_DONE  = 2'd2;
    localparam logic [1:0] MODE_FAIL  = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [13:0] message_length;
        logic [7:0]  data_byte;
    } t_in_word;

    typedef struct packed {
        logic        byte_valid;
        logic [7:0]  tx_byte;
        logic        chunk_last;
        logic        begin_accepted;
        logic        idle;
        logic [31:0] dropped_total;
        logic [31:0] error_total;
    } t_out_word;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_LEN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic item_accept;
        logic status_load;
        logic emit_start;
        logic len_latch;
        logic emit_step;
    } t_ctl_cmd;

    typedef struct packed {
        logic emit_needed;
        logic emit_last;
    } t_dp_status;

endpackage

/* design/ctq_ram.sv */
module ctq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* design/ctq_ctrl.sv */
module ctq_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  ctq_pkg::t_dp_status i_status,
    output ctq_pkg::t_ctl_cmd   o_cmd,
    output logic                o_busy
);

    ctq_pkg::t_state r_state;
    ctq_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ctq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        case (r_state)
            ctq_pkg::ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.item_accept = 1'b1;
                    n_state = ctq_pkg::ST_CHECK;
                end
            end
            ctq_pkg::ST_CHECK: begin
                if (i_status.emit_needed) begin
                    o_cmd.emit_start = 1'b1;
                    n_state = ctq_pkg::ST_LEN;
                end else begin
                    o_cmd.status_load = 1'b1;
                    n_state = ctq_pkg::ST_IDLE;
                end
            end
            ctq_pkg::ST_LEN: begin
                o_cmd.len_latch = 1'b1;
                n_state = ctq_pkg::ST_EMIT;
            end
            ctq_pkg::ST_EMIT: begin
                o_cmd.emit_step = 1'b1;
                if (i_status.emit_last) begin
                    n_state = ctq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ctq_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* design/ctq_datapath.sv */
module ctq_datapath #(
    parameter int CHUNK_BYTES = 64,
    parameter int SLOT_COUNT  = 128
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ctq_pkg::t_in_word   i_item,
    input  ctq_pkg::t_ctl_cmd   i_cmd,
    output ctq_pkg::t_dp_status o_status,
    output logic                o_strobe,
    output ctq_pkg::t_out_word  o_result
);

    localparam int SLOT_W   = $clog2(SLOT_COUNT);
    localparam int OCC_W    = $clog2(SLOT_COUNT + 1);
    localparam int POS_W    = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;
    localparam int LEN_W    = $clog2(CHUNK_BYTES + 1);
    localparam int ST_DEPTH = SLOT_COUNT * CHUNK_BYTES;
    localparam int ST_AW    = $clog2(ST_DEPTH);
    localparam int PROD_W   = OCC_W + LEN_W;
    localparam int CMP_W    = (PROD_W > 14) ? PROD_W : 14;

    logic [SLOT_W-1:0] r_wslot, n_wslot;
    logic [SLOT_W-1:0] r_rslot, n_rslot;
    logic [OCC_W-1:0]  r_occ, n_occ;
    logic              r_tx_busy, n_tx_busy;
    logic [31:0]       r_dropped, n_dropped;
    logic [31:0]       r_errors, n_errors;
    logic              r_begin_ok, n_begin_ok;
    logic              r_fill_active, n_fill_active;
    logic [13:0]       r_fill_remaining, n_fill_remaining;
    logic [POS_W-1:0]  r_fill_pos, n_fill_pos;
    logic [SLOT_W-1:0] r_fill_slot, n_fill_slot;
    logic [OCC_W-1:0]  r_fill_chunks, n_fill_chunks;
    logic [LEN_W-1:0]  r_emit_len, n_emit_len;
    logic [POS_W-1:0]  r_emit_idx, n_emit_idx;
    logic              r_strobe, n_strobe;
    ctq_pkg::t_out_word r_out, n_out;

    logic [OCC_W-1:0]  free_slots;
    logic [CMP_W-1:0]  free_bytes;
    logic              wr_en;
    logic [ST_AW-1:0]  st_wr_addr;
    logic [ST_AW-1:0]  st_rd_addr;
    logic [POS_W-1:0]  rd_idx;
    logic [7:0]        st_rd_data;
    logic [LEN_W-1:0]  len_rd_data;
    logic [LEN_W-1:0]  len_clamped;
    logic              emit_last;
    logic [SLOT_W-1:0] fill_slot_inc;

    assign free_slots = OCC_W'(SLOT_COUNT) - r_occ;
    assign free_bytes = CMP_W'(free_slots) * CMP_W'(CHUNK_BYTES);
    assign fill_slot_inc = (r_fill_slot == SLOT_W'(SLOT_COUNT - 1)) ? '0
                                                                      : r_fill_slot + 1'b1;
    assign emit_last = ((LEN_W'(r_emit_idx) + 1'b1) == r_emit_len);
    assign rd_idx = i_cmd.len_latch ? '0 : (emit_last ? r_emit_idx : r_emit_idx + 1'b1);
    assign st_wr_addr = ST_AW'(r_fill_slot) * ST_AW'(CHUNK_BYTES) + ST_AW'(r_fill_pos);
    assign st_rd_addr = ST_AW'(r_rslot) * ST_AW'(CHUNK_BYTES) + ST_AW'(rd_idx);
    assign wr_en = i_cmd.item_accept && (i_item.mode == ctq_pkg::MODE_BYTE) && r_fill_active;

    always_comb begin
        if (len_rd_data == '0) begin
            len_clamped = LEN_W'(1);
        end else if (len_rd_data > LEN_W'(CHUNK_BYTES)) begin
            len_clamped = LEN_W'(CHUNK_BYTES);
        end else begin
            len_clamped = len_rd_data;
        end
    end

    ctq_ram #(
        .WIDTH(8),
        .DEPTH(ST_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (st_wr_addr),
        .i_wr_data (i_item.data_byte),
        .i_rd_addr (st_rd_addr),
        .o_rd_data (st_rd_data)
    );

    ctq_ram #(
        .WIDTH(LEN_W),
        .DEPTH(SLOT_COUNT)
    ) u_lengths (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_fill_slot),
        .i_wr_data (LEN_W'(r_fill_pos) + 1'b1),
        .i_rd_addr (r_rslot),
        .o_rd_data (len_rd_data)
    );

    always_comb begin
        n_wslot          = r_wslot;
        n_rslot          = r_rslot;
        n_occ            = r_occ;
        n_tx_busy        = r_tx_busy;
        n_dropped        = r_dropped;
        n_errors         = r_errors;
        n_begin_ok       = r_begin_ok;
        n_fill_active    = r_fill_active;
        n_fill_remaining = r_fill_remaining;
        n_fill_pos       = r_fill_pos;
        n_fill_slot      = r_fill_slot;
        n_fill_chunks    = r_fill_chunks;
        n_emit_len       = r_emit_len;
        n_emit_idx       = r_emit_idx;
        n_strobe         = i_cmd.status_load | i_cmd.emit_step;
        n_out            = r_out;

        if (i_cmd.item_accept) begin
            case (i_item.mode)
                ctq_pkg::MODE_BEGIN: begin
                    if (i_item.message_length != '0) begin
                        n_fill_active = 1'b0;
                        if (CMP_W'(i_item.message_length) > free_bytes) begin
                            n_dropped  = r_dropped + 1'b1;
                            n_begin_ok = 1'b0;
                        end else begin
                            n_fill_active    = 1'b1;
                            n_fill_remaining = i_item.message_length;
                            n_fill_pos       = '0;
                            n_fill_slot      = r_wslot;
                            n_fill_chunks    = OCC_W'(1);
                            n_begin_ok       = 1'b1;
                        end
                    end
                end
                ctq_pkg::MODE_BYTE: begin
                    if (r_fill_active) begin
                        if (r_fill_pos == POS_W'(CHUNK_BYTES - 1)) begin
                            n_fill_pos    = '0;
                            n_fill_slot   = fill_slot_inc;
                            n_fill_chunks = r_fill_chunks + 1'b1;
                        end else begin
                            n_fill_pos = r_fill_pos + 1'b1;
                        end
                        n_fill_remaining = r_fill_remaining - 1'b1;
                        if (r_fill_remaining == 14'd1) begin
                            n_occ         = r_occ + r_fill_chunks;
                            n_wslot       = fill_slot_inc;
                            n_fill_active = 1'b0;
                        end
                    end
                end
                ctq_pkg::MODE_DONE, ctq_pkg::MODE_FAIL: begin
                    if (r_tx_busy) begin
                        n_tx_busy = 1'b0;
                        n_occ     = r_occ - 1'b1;
                        n_rslot   = (r_rslot == SLOT_W'(SLOT_COUNT - 1)) ? '0
                                                                          : r_rslot + 1'b1;
                        if (i_item.mode == ctq_pkg::MODE_FAIL) begin
                            n_dropped = r_dropped + 1'b1;
                            n_errors  = r_errors + 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        if (i_cmd.emit_start) begin
            n_tx_busy = 1'b1;
        end

        if (i_cmd.len_latch) begin
            n_emit_len = len_clamped;
            n_emit_idx = '0;
        end

        if (i_cmd.emit_step && !emit_last) begin
            n_emit_idx = r_emit_idx + 1'b1;
        end

        if (i_cmd.status_load) begin
            n_out.byte_valid     = 1'b0;
            n_out.tx_byte        = 8'd0;
            n_out.chunk_last     = 1'b1;
            n_out.begin_accepted = r_begin_ok;
            n_out.idle           = (r_occ == '0) && !r_tx_busy;
            n_out.dropped_total  = r_dropped;
            n_out.error_total    = r_errors;
        end else if (i_cmd.emit_step) begin
            n_out.byte_valid     = 1'b1;
            n_out.tx_byte        = st_rd_data;
            n_out.chunk_last     = emit_last;
            n_out.begin_accepted = r_begin_ok;
            n_out.idle           = 1'b0;
            n_out.dropped_total  = r_dropped;
            n_out.error_total    = r_errors;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wslot          <= '0;
            r_rslot          <= '0;
            r_occ            <= '0;
            r_tx_busy        <= 1'b0;
            r_dropped        <= '0;
            r_errors         <= '0;
            r_begin_ok       <= 1'b0;
            r_fill_active    <= 1'b0;
            r_fill_remaining <= '0;
            r_fill_pos       <= '0;
            r_fill_slot      <= '0;
            r_fill_chunks    <= '0;
            r_emit_len       <= '0;
            r_emit_idx       <= '0;
            r_strobe         <= 1'b0;
        end else begin
            r_wslot          <= n_wslot;
            r_rslot          <= n_rslot;
            r_occ            <= n_occ;
            r_tx_busy        <= n_tx_busy;
            r_dropped        <= n_dropped;
            r_errors         <= n_errors;
            r_begin_ok       <= n_begin_ok;
            r_fill_active    <= n_fill_active;
            r_fill_remaining <= n_fill_remaining;
            r_fill_pos       <= n_fill_pos;
            r_fill_slot      <= n_fill_slot;
            r_fill_chunks    <= n_fill_chunks;
            r_emit_len       <= n_emit_len;
            r_emit_idx       <= n_emit_idx;
            r_strobe         <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_status.emit_needed = !r_tx_busy && (r_occ != '0);
    assign o_status.emit_last   = emit_last;
    assign o_strobe = r_strobe;
    assign o_result = r_out;

endmodule

/* design/chunked_transmit_queue_unit.sv */
// Channel   Ports                      Transfer
// command   i_start, i_item, o_busy    word taken when i_start is high and o_busy is low
// result    o_strobe, o_result         word valid for the single cycle o_strobe is high
//
// A word that starts no chunk keeps the unit busy while the control decides after it
// is taken, and its status word appears on the cycle after that decision.
// A word that starts a chunk of n bytes keeps the unit busy to decide, then for the chunk
// length memory read, then for one byte per cycle from the chunk store.
// Reset is synchronous and clears all control state; the memories are not cleared.
// The receiver cannot stall, so result words are never held back.
module chunked_transmit_queue_unit #(
    parameter int CHUNK_BYTES = 64,
    parameter int SLOT_COUNT  = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  ctq_pkg::t_in_word  i_item,
    output logic               o_busy,
    output logic               o_strobe,
    output ctq_pkg::t_out_word o_result
);

    ctq_pkg::t_ctl_cmd   cmd;
    ctq_pkg::t_dp_status status;

    ctq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (o_busy)
    );

    ctq_datapath #(
        .CHUNK_BYTES (CHUNK_BYTES),
        .SLOT_COUNT  (SLOT_COUNT)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_status (status),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

/* bench/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CHUNK        = 64;
    localparam int SLOTS        = 128;
    localparam int WORD_TARGET  = 230;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 80;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_start = 1'b0;
    ctq_pkg::t_in_word  i_item  = '0;
    logic               o_busy;
    logic               o_strobe;
    ctq_pkg::t_out_word o_result;

    chunked_transmit_queue_unit #(
        .CHUNK_BYTES(CHUNK),
        .SLOT_COUNT (SLOTS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_item  (i_item),
        .o_busy  (o_busy),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

    logic [7:0]  byte_store [CHUNK*SLOTS];
    logic [6:0]  slot_len [SLOTS];
    logic [7:0]  wr_seq      = '0;
    logic [7:0]  rd_seq      = '0;
    logic        tx_busy     = 1'b0;
    logic        filling     = 1'b0;
    logic        begin_ok    = 1'b0;
    logic [13:0] fill_left   = '0;
    logic [12:0] fill_pos    = '0;
    logic [7:0]  reserved    = '0;
    logic [31:0] drop_total  = '0;
    logic [31:0] fail_total  = '0;

    ctq_pkg::t_in_word  cmd_words[$];
    ctq_pkg::t_out_word queue_out_words[$];

    int gap_left     = 0;
    int burst_left   = 0;
    int quiet_cycles = 0;
    int fault_count  = 0;
    int words_taken  = 0;
    int words_seen   = 0;
    int chunks_sent  = 0;
    int mode_seen [4] = '{0, 0, 0, 0};

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function logic [7:0] slots_in_use();
        return wr_seq - rd_seq;
    endfunction

    function ctq_pkg::t_out_word tx_status(logic valid, logic [7:0] data, logic fin);
        ctq_pkg::t_out_word w;
        w.byte_valid     = valid;
        w.tx_byte        = data;
        w.chunk_last     = fin;
        w.begin_accepted = begin_ok;
        w.idle           = (slots_in_use() == 8'd0) && !tx_busy;
        w.dropped_total  = drop_total;
        w.error_total    = fail_total;
        return w;
    endfunction

    task automatic advance_queue(input ctq_pkg::t_in_word w);
        int chunks;
        int base;
        int n;
        case (w.mode)
            ctq_pkg::MODE_BEGIN: begin
                if (w.message_length != '0) begin
                    filling = 1'b0;
                    chunks  = (int'(w.message_length) + CHUNK - 1) / CHUNK;
                    if (chunks > SLOTS || int'(slots_in_use()) + chunks > SLOTS) begin
                        drop_total++;
                        begin_ok = 1'b0;
                    end else begin
                        filling   = 1'b1;
                        fill_left = w.message_length;
                        fill_pos  = '0;
                        reserved  = 8'(chunks);
                        begin_ok  = 1'b1;
                    end
                end
            end
            ctq_pkg::MODE_BYTE: begin
                if (filling) begin
                    base = ((int'(wr_seq) + int'(fill_pos) / CHUNK) % SLOTS) * CHUNK;
                    byte_store[base + int'(fill_pos) % CHUNK] = w.data_byte;
                    slot_len[base / CHUNK] = 7'(int'(fill_pos) % CHUNK + 1);
                    fill_pos++;
                    fill_left--;
                    if (fill_left == '0) begin
                        wr_seq  = wr_seq + reserved;
                        filling = 1'b0;
                    end
                end
            end
            default: begin
                if (tx_busy) begin
                    tx_busy = 1'b0;
                    rd_seq++;
                    if (w.mode == ctq_pkg::MODE_FAIL) begin
                        drop_total++;
                        fail_total++;
                    end
                end
            end
        endcase
        if (tx_busy || slots_in_use() == 8'd0) begin
            queue_out_words.push_back(tx_status(1'b0, 8'h00, 1'b1));
        end else begin
            base = int'(rd_seq) % SLOTS;
            n    = int'(slot_len[base]);
            if (n == 0) n = 1;
            if (n > CHUNK) n = CHUNK;
            tx_busy = 1'b1;
            chunks_sent++;
            for (int i = 0; i < n; i++) begin
                queue_out_words.push_back(
                    tx_status(1'b1, byte_store[base*CHUNK + i], i == n - 1));
            end
        end
    endtask

    task automatic queue_cmd(input logic [1:0] m, input logic [13:0] len, input logic [7:0] d);
        ctq_pkg::t_in_word w;
        w.mode           = m;
        w.message_length = len;
        w.data_byte      = d;
        cmd_words.push_back(w);
    endtask

    task automatic queue_message(input int len, input int sent);
        queue_cmd(ctq_pkg::MODE_BEGIN, 14'(len), 8'($urandom));
        repeat (sent) queue_cmd(ctq_pkg::MODE_BYTE, 14'($urandom), 8'($urandom));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
            i_item  <= '0;
            gap_left = 0;
        end else begin
            if (i_start && !o_busy) begin
                advance_queue(i_item);
                words_taken++;
                mode_seen[i_item.mode]++;
                if (burst_left > 0) begin
                    burst_left--;
                    gap_left = 0;
                end else begin
                    gap_left = $urandom_range(0, 3);
                    if ($urandom_range(0, 15) == 0) burst_left = $urandom_range(10, 30);
                end
            end
            if (!i_start || !o_busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_start <= 1'b0;
                end else if (cmd_words.size() > 0) begin
                    i_item  <= cmd_words.pop_front();
                    i_start <= 1'b1;
                end else begin
                    i_start <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            words_seen++;
            if (queue_out_words.size() == 0) begin
                if (fault_count < 10) begin
                    $display("Unexpected result word: valid=%0b byte=%02h last=%0b",
                             o_result.byte_valid, o_result.tx_byte, o_result.chunk_last);
                end
                fault_count++;
            end else begin
                ctq_pkg::t_out_word e;
                e = queue_out_words.pop_front();
                if (o_result.byte_valid !== e.byte_valid || o_result.tx_byte !== e.tx_byte ||
                    o_result.chunk_last !== e.chunk_last ||
                    o_result.begin_accepted !== e.begin_accepted ||
                    o_result.idle !== e.idle || o_result.dropped_total !== e.dropped_total ||
                    o_result.error_total !== e.error_total) begin
                    if (fault_count < 10) begin
                        $display("Mismatch on result %0d:", words_seen);
                        $display({"  expected valid=%0b byte=%02h last=%0b acc=%0b idle=%0b",
                                  " drop=%0d err=%0d"},
                                 e.byte_valid, e.tx_byte, e.chunk_last, e.begin_accepted,
                                 e.idle, e.dropped_total, e.error_total);
                        $display({"  actual   valid=%0b byte=%02h last=%0b acc=%0b idle=%0b",
                                  " drop=%0d err=%0d"},
                                 o_result.byte_valid, o_result.tx_byte, o_result.chunk_last,
                                 o_result.begin_accepted, o_result.idle,
                                 o_result.dropped_total, o_result.error_total);
                    end
                    fault_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_start && !o_busy) || o_strobe) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Timeout after %0d cycles with no word moving.", quiet_cycles);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        int counted;
        int pick;
        int len;
        int sent;
        counted = 0;

        queue_cmd(ctq_pkg::MODE_BYTE, 14'h3FFF, 8'hFF);
        queue_cmd(ctq_pkg::MODE_DONE, 14'h0000, 8'h00);
        queue_cmd(ctq_pkg::MODE_FAIL, 14'h2AAA, 8'h55);
        queue_cmd(ctq_pkg::MODE_BEGIN, 14'd0, 8'h00);
        queue_cmd(ctq_pkg::MODE_BEGIN, 14'h3FFF, 8'h00);
        queue_cmd(ctq_pkg::MODE_BEGIN, 14'd8192, 8'h00);
        queue_cmd(ctq_pkg::MODE_BEGIN, 14'd3, 8'h00);
        queue_cmd(ctq_pkg::MODE_BYTE, 14'h0000, 8'h00);
        queue_cmd(ctq_pkg::MODE_BYTE, 14'h1555, 8'hFF);
        queue_cmd(ctq_pkg::MODE_BYTE, 14'h3FFF, 8'hA5);
        queue_cmd(ctq_pkg::MODE_BEGIN, 14'd8192, 8'hFF);
        queue_cmd(ctq_pkg::MODE_BYTE, 14'h0000, 8'h11);
        queue_cmd(ctq_pkg::MODE_BEGIN, 14'd0, 8'hFF);
        queue_cmd(ctq_pkg::MODE_FAIL, 14'h0000, 8'h00);
        queue_cmd(ctq_pkg::MODE_DONE, 14'h0000, 8'h00);
        queue_cmd(ctq_pkg::MODE_BEGIN, 14'd1, 8'h00);
        queue_cmd(ctq_pkg::MODE_BYTE, 14'h0000, 8'h80);
        queue_cmd(ctq_pkg::MODE_DONE, 14'h3FFF, 8'hFF);
        counted = cmd_words.size();

        while (counted < WORD_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                pick = $urandom_range(0, 99);
                if (pick < 65) len = $urandom_range(1, 12);
                else if (pick < 90) len = $urandom_range(13, 40);
                else len = $urandom_range(60, 70);
                queue_message(len, len);
                counted += len + 1;
                repeat ($urandom_range(0, 2)) begin
                    queue_cmd(($urandom_range(0, 3) == 0) ? ctq_pkg::MODE_FAIL
                                                          : ctq_pkg::MODE_DONE,
                              14'($urandom), 8'($urandom));
                    counted++;
                end
            end else if (pick < 75) begin
                len  = $urandom_range(2, 30);
                sent = $urandom_range(1, len - 1);
                queue_message(len, sent);
                counted += sent + 1;
            end else if (pick < 87) begin
                queue_cmd(ctq_pkg::MODE_BEGIN, 14'($urandom_range(1024, 16383)), 8'($urandom));
                counted++;
                sent = $urandom_range(0, 3);
                repeat (sent) begin
                    queue_cmd(ctq_pkg::MODE_BYTE, 14'($urandom), 8'($urandom));
                end
                counted += sent;
            end else begin
                queue_cmd(2'($urandom_range(0, 3)), 14'($urandom), 8'($urandom));
                counted++;
            end
        end
        repeat (6) queue_cmd(ctq_pkg::MODE_DONE, 14'($urandom), 8'($urandom));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_words.size() != 0 || i_start || queue_out_words.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (queue_out_words.size() != 0) begin
            $display("%0d result words never arrived.", queue_out_words.size());
            fault_count++;
        end
        $display("Sent %0d command words (%0d begins, %0d bytes, %0d done, %0d failed).",
                 words_taken, mode_seen[0], mode_seen[1], mode_seen[2], mode_seen[3]);
        $display("Checked %0d result words covering %0d chunks, %0d drops and %0d failures.",
                 words_seen, chunks_sent, drop_total, fail_total);
        if (fault_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

/* chunked_transmit_queue_unit.f */
design/ctq_pkg.sv
design/ctq_ram.sv
design/ctq_ctrl.sv
design/ctq_datapath.sv
design/chunked_transmit_queue_unit.sv
bench/testbench.sv
